// ===== rtl/core/dccd_pkg.sv =====
// Shared types and constants of the digit canvas centering downsampler.
// Field widths, stream packing offsets, action codes and register indexes.
// No dependencies; imported by every module of the block.
package dccd_pkg;

  localparam int CFG_W        = 9;
  localparam int CFG_IDX_W    = 2;
  localparam int ACTION_W     = 2;
  localparam int COORD_W      = 9;
  localparam int RED_W        = 8;
  localparam int CELL_IDX_W   = 5;
  localparam int CELL_VALUE_W = 8;
  localparam int SHIFT_W      = 9;

  // Input word packing, lowest bit first.
  localparam int X_LSB     = 0;
  localparam int Y_LSB     = X_LSB + COORD_W;
  localparam int RED_LSB   = Y_LSB + COORD_W;
  localparam int ROW_LSB   = RED_LSB + RED_W;
  localparam int COL_LSB   = ROW_LSB + CELL_IDX_W;
  localparam int S_TDATA_W = 40;

  // Output word packing, lowest bit first.
  localparam int VAL_LSB    = 0;
  localparam int INK_LSB    = VAL_LSB + CELL_VALUE_W;
  localparam int LEFT_LSB   = INK_LSB + 1;
  localparam int TOP_LSB    = LEFT_LSB + COORD_W;
  localparam int RIGHT_LSB  = TOP_LSB + COORD_W;
  localparam int BOTTOM_LSB = RIGHT_LSB + COORD_W;
  localparam int SX_LSB     = BOTTOM_LSB + COORD_W;
  localparam int SY_LSB     = SX_LSB + SHIFT_W;
  localparam int M_TDATA_W  = 64;

  localparam int RST_SIDE  = 280;
  localparam int INK_MAX   = 255;
  localparam int SHIFT_MAX = 255;
  localparam int SHIFT_MIN = -256;

  typedef enum logic [ACTION_W-1:0] {
    ACT_CLEAR = 2'd0,
    ACT_PIXEL = 2'd1,
    ACT_CELL  = 2'd2
  } action_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CANVAS_WIDTH  = 2'd0,
    REG_CANVAS_HEIGHT = 2'd1
  } cfg_reg_t;

endpackage

// ===== rtl/core/dccd_div.sv =====
// Restoring divider producing one quotient bit per cycle.
// The quotient is known to fit in CELL_VALUE_W bits; depends on dccd_pkg.
module dccd_div #(
  parameter int DVD_W = 22,
  parameter int DVS_W = 14
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  input  logic [DVD_W-1:0]                   dividend,
  input  logic [DVS_W-1:0]                   divisor,
  output logic                               done,
  output logic [dccd_pkg::CELL_VALUE_W-1:0]  quotient
);
  import dccd_pkg::*;

  localparam int RW    = DVS_W + CELL_VALUE_W;
  localparam int CNT_W = $clog2(CELL_VALUE_W);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [RW-1:0]    rem;
  logic [RW-1:0]    dsh;
  logic             ge;

  assign ge = (rem >= dsh);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(CELL_VALUE_W - 1);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= RW'(dividend);
      dsh <= RW'(divisor) << (CELL_VALUE_W - 1);
    end else if (busy) begin
      if (ge) begin
        rem <= rem - dsh;
      end
      quotient <= {quotient[CELL_VALUE_W-2:0], ge};
      dsh      <= dsh >> 1;
    end
  end

endmodule

// ===== rtl/core/digit_canvas_center_downsample.sv =====
// Top level of the digit canvas centering downsampler: frame memory, ink box
// tracking, cell scan sequencer and output register. Depends on dccd_pkg and
// on the iterative divider dccd_div.
//
//   Channel   Direction  Handshake          Carries
//   s_*       in         s_tvalid/s_tready  action (tuser), pixel or cell request (tdata)
//   m_*       out        m_tvalid/m_tready  cell average, ink box and shifts (tdata)
//   cfg_*     in         cfg_wen            canvas width and height registers
//
// A clear, a pixel write or an unused action is finished at acceptance, so such
// words can be accepted back to back. A cell read steps through every pixel of
// the cell, cw x ch pixels, reading the frame memory for those inside the canvas,
// after setup; then come the registered memory read and eight divider steps.
// Reset is synchronous and clears control state and the ink box; the frame memory
// is not cleared and holds whatever was written. The input stalls during a cell
// read and after each configuration write, while the derived
// canvas sizes settle. A finished result waits in the output register, and the
// next input word is accepted while it waits; a further cell result waits in the
// sequencer until the output register is free.
module digit_canvas_center_downsample #(
  parameter int MAX_SIDE  = 448,
  parameter int GRID_SIZE = 28
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  // Fields from bit 0 up: pixel_x, pixel_y, red_level, cell_row, cell_col.
  input  logic [dccd_pkg::S_TDATA_W-1:0]     s_tdata,
  // Fields from bit 0 up: action.
  input  logic [dccd_pkg::ACTION_W-1:0]      s_tuser,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // Fields from bit 0 up: cell_value, ink_found, box_left, box_top, box_right,
  // box_bottom, shift_x, shift_y.
  output logic [dccd_pkg::M_TDATA_W-1:0]     m_tdata,
  input  logic                               cfg_wen,
  input  logic [dccd_pkg::CFG_IDX_W-1:0]     cfg_idx,
  input  logic [dccd_pkg::CFG_W-1:0]         cfg_wdata
);
  import dccd_pkg::*;

  // Memory geometry.
  localparam int DEPTH = MAX_SIDE * MAX_SIDE;
  localparam int AW    = $clog2(DEPTH);

  // Cell size in pixels along one axis never exceeds the largest register value
  // divided by the grid size.
  localparam int CW_W  = $clog2((2 ** CFG_W - 1) / GRID_SIZE + 1);
  localparam int NP_W  = 2 * CW_W;
  localparam int SUM_W = CELL_VALUE_W + NP_W;
  localparam int CRD_W = COORD_W + CELL_IDX_W + 1;

  // Division by the grid size as a multiplication by a rounded-up reciprocal.
  // With a 16-bit scale the result is exact for every 9-bit register value.
  localparam int RCP_SH = 16;
  localparam int RCP    = (2 ** RCP_SH + GRID_SIZE - 1) / GRID_SIZE;
  localparam int PROD_W = CFG_W + RCP_SH;

  localparam int RST_CLAMP = (RST_SIDE < GRID_SIZE) ? GRID_SIZE :
                             ((RST_SIDE > MAX_SIDE) ? MAX_SIDE : RST_SIDE);
  localparam int RST_CELLS = RST_CLAMP / GRID_SIZE;
  localparam int RST_USED  = RST_CELLS * GRID_SIZE;

  localparam logic signed [CRD_W-1:0] SAT_LO = CRD_W'(SHIFT_MIN);
  localparam logic signed [CRD_W-1:0] SAT_HI = CRD_W'(SHIFT_MAX);

  typedef enum logic [7:0] {
    ST_IDLE   = 8'b0000_0001,
    ST_SETUP  = 8'b0000_0010,
    ST_BASE   = 8'b0000_0100,
    ST_SCAN   = 8'b0000_1000,
    ST_DRAIN  = 8'b0001_0000,
    ST_DIVS   = 8'b0010_0000,
    ST_DIVW   = 8'b0100_0000,
    ST_FINISH = 8'b1000_0000
  } state_t;

  // Number of grid cells along an axis for a raw register value: the value is
  // clamped to the legal canvas range and divided by the grid size.
  function automatic logic [CW_W-1:0] cells_of(input logic [CFG_W-1:0] v);
    logic [CFG_W-1:0]  c;
    logic [PROD_W-1:0] p;
    if (32'(v) < GRID_SIZE) begin
      c = CFG_W'(GRID_SIZE);
    end else if (32'(v) > MAX_SIDE) begin
      c = CFG_W'(MAX_SIDE);
    end else begin
      c = v;
    end
    p = PROD_W'(c) * PROD_W'(RCP);
    return CW_W'(p >> RCP_SH);
  endfunction

  // Saturates a centering shift to the width of its output field.
  function automatic logic [SHIFT_W-1:0] sat_shift(input logic signed [CRD_W-1:0] s);
    logic [SHIFT_W-1:0] r;
    if (s < SAT_LO) begin
      r = SHIFT_W'(SAT_LO);
    end else if (s > SAT_HI) begin
      r = SHIFT_W'(SAT_HI);
    end else begin
      r = s[SHIFT_W-1:0];
    end
    return r;
  endfunction

  state_t state, state_next;

  // Input word fields.
  logic [COORD_W-1:0]    in_x, in_y;
  logic [RED_W-1:0]      in_red;
  logic [CELL_IDX_W-1:0] in_row, in_col;
  logic                  accept;

  assign in_x   = s_tdata[X_LSB   +: COORD_W];
  assign in_y   = s_tdata[Y_LSB   +: COORD_W];
  assign in_red = s_tdata[RED_LSB +: RED_W];
  assign in_row = s_tdata[ROW_LSB +: CELL_IDX_W];
  assign in_col = s_tdata[COL_LSB +: CELL_IDX_W];
  assign accept = s_tvalid && s_tready;

  // Canvas geometry. The cell counts are written by the configuration port;
  // the used sides and the pixel count per cell follow in the next cycle, and
  // cfg_hold keeps the input closed until they do.
  logic [CW_W-1:0]    cw, ch;
  logic [COORD_W-1:0] w, h;
  logic [NP_W-1:0]    npix;
  logic               cfg_hold;

  always_ff @(posedge clk) begin
    if (rst) begin
      cw       <= CW_W'(RST_CELLS);
      ch       <= CW_W'(RST_CELLS);
      w        <= COORD_W'(RST_USED);
      h        <= COORD_W'(RST_USED);
      npix     <= NP_W'(RST_CELLS * RST_CELLS);
      cfg_hold <= 1'b0;
    end else begin
      cfg_hold <= cfg_wen;
      if (cfg_wen) begin
        unique case (cfg_idx)
          REG_CANVAS_WIDTH:  cw <= cells_of(cfg_wdata);
          REG_CANVAS_HEIGHT: ch <= cells_of(cfg_wdata);
          default: ;
        endcase
      end
      w    <= COORD_W'(32'(cw) * GRID_SIZE);
      h    <= COORD_W'(32'(ch) * GRID_SIZE);
      npix <= NP_W'(cw) * NP_W'(ch);
    end
  end

  assign s_tready = (state == ST_IDLE) && !cfg_hold;

  // Ink bounding box. Only ink inside the canvas in use widens it.
  logic [COORD_W-1:0] ink_left, ink_top, ink_right, ink_bottom;
  logic               ink_seen;
  logic               in_range;
  logic               mem_we;

  assign in_range = (32'(in_x) < MAX_SIDE) && (32'(in_y) < MAX_SIDE);
  assign mem_we   = accept && (s_tuser == ACT_PIXEL) && in_range;

  always_ff @(posedge clk) begin
    if (rst) begin
      ink_left   <= '1;
      ink_top    <= '1;
      ink_right  <= '0;
      ink_bottom <= '0;
      ink_seen   <= 1'b0;
    end else if (accept) begin
      unique case (s_tuser)
        ACT_CLEAR: begin
          ink_left   <= '1;
          ink_top    <= '1;
          ink_right  <= '0;
          ink_bottom <= '0;
          ink_seen   <= 1'b0;
        end
        ACT_PIXEL: begin
          if (in_range && (in_red == '0) && (in_x < w) && (in_y < h)) begin
            if (!ink_seen || (in_x < ink_left))   ink_left   <= in_x;
            if (!ink_seen || (in_y < ink_top))    ink_top    <= in_y;
            if (!ink_seen || (in_x > ink_right))  ink_right  <= in_x;
            if (!ink_seen || (in_y > ink_bottom)) ink_bottom <= in_y;
            ink_seen <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // Cell request latched at acceptance.
  logic [CELL_IDX_W-1:0] req_row, req_col;

  always_ff @(posedge clk) begin
    if (accept) begin
      req_row <= in_row;
      req_col <= in_col;
    end
  end

  // Centering shifts and cell origin. The box center is low plus half the
  // box extent, rounded down; the canvas center is half the side, rounded down.
  logic signed [CRD_W-1:0] dx, dy, sx_calc, sy_calc;
  logic signed [CRD_W-1:0] sx, sy;
  logic [CRD_W-1:0]        prod_r, prod_c;
  logic signed [CRD_W-1:0] r_cur, c_cur, base_c;
  logic [CW_W-1:0]         i_cnt, j_cnt;
  logic                    row_end, cell_end;

  always_comb begin
    dx      = $signed(CRD_W'(ink_right)) - $signed(CRD_W'(ink_left));
    dy      = $signed(CRD_W'(ink_bottom)) - $signed(CRD_W'(ink_top));
    sx_calc = $signed(CRD_W'(ink_left)) + (dx >>> 1) - $signed(CRD_W'(w >> 1));
    sy_calc = $signed(CRD_W'(ink_top)) + (dy >>> 1) - $signed(CRD_W'(h >> 1));
  end

  always_ff @(posedge clk) begin
    if (state == ST_SETUP) begin
      sx     <= ink_seen ? sx_calc : '0;
      sy     <= ink_seen ? sy_calc : '0;
      prod_r <= CRD_W'(req_row) * CRD_W'(ch);
      prod_c <= CRD_W'(req_col) * CRD_W'(cw);
    end
  end

  assign row_end  = (j_cnt == cw - 1'b1);
  assign cell_end = row_end && (i_cnt == ch - 1'b1);

  // The scan walks the cell row by row and reads the memory only for pixels inside the canvas.
  always_ff @(posedge clk) begin
    if (state == ST_BASE) begin
      r_cur  <= $signed(prod_r) + sy;
      c_cur  <= $signed(prod_c) + sx;
      base_c <= $signed(prod_c) + sx;
      i_cnt  <= '0;
      j_cnt  <= '0;
    end else if (state == ST_SCAN) begin
      if (row_end) begin
        j_cnt <= '0;
        c_cur <= base_c;
        i_cnt <= i_cnt + 1'b1;
        r_cur <= r_cur + CRD_W'(1);
      end else begin
        j_cnt <= j_cnt + 1'b1;
        c_cur <= c_cur + CRD_W'(1);
      end
    end
  end

  // Frame memory. Writes happen only on accepted pixel words, reads only
  // during a scan, so the two never meet on the same entry in flight.
  logic [RED_W-1:0] frame_mem [DEPTH];
  logic [RED_W-1:0] rd_data;
  logic [AW-1:0]    wr_addr, rd_addr;
  logic             r_ok, c_ok, rd_en, rd_valid;

  assign wr_addr = AW'(in_y) * AW'(MAX_SIDE) + AW'(in_x);
  assign r_ok    = !r_cur[CRD_W-1] && ($unsigned(r_cur) < CRD_W'(h));
  assign c_ok    = !c_cur[CRD_W-1] && ($unsigned(c_cur) < CRD_W'(w));
  assign rd_en   = (state == ST_SCAN) && r_ok && c_ok;
  assign rd_addr = AW'(r_cur[COORD_W-1:0]) * AW'(MAX_SIDE) + AW'(c_cur[COORD_W-1:0]);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      frame_mem[wr_addr] <= in_red;
    end
    if (rd_en) begin
      rd_data <= frame_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid <= 1'b0;
    end else begin
      rd_valid <= rd_en;
    end
  end

  // Sum of inverted pixels; pixels outside the canvas are never read and so
  // add nothing.
  logic [SUM_W-1:0] sum;

  always_ff @(posedge clk) begin
    if (state == ST_SETUP) begin
      sum <= '0;
    end else if (rd_valid) begin
      sum <= sum + SUM_W'(RED_W'(INK_MAX) - rd_data);
    end
  end

  // Average over the whole cell, including pixels outside the canvas.
  logic                    div_done;
  logic [CELL_VALUE_W-1:0] div_q;

  dccd_div #(
    .DVD_W (SUM_W),
    .DVS_W (NP_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (state == ST_DIVS),
    .dividend (sum),
    .divisor  (npix),
    .done     (div_done),
    .quotient (div_q)
  );

  // Sequencer.
  logic out_free;

  assign out_free = !m_tvalid || m_tready;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept && (s_tuser == ACT_CELL)) state_next = ST_SETUP;
      end
      ST_SETUP:  state_next = ST_BASE;
      ST_BASE:   state_next = ST_SCAN;
      ST_SCAN: begin
        if (cell_end) state_next = ST_DRAIN;
      end
      ST_DRAIN:  state_next = ST_DIVS;
      ST_DIVS:   state_next = ST_DIVW;
      ST_DIVW: begin
        if (div_done) state_next = ST_FINISH;
      end
      ST_FINISH: begin
        if (out_free) state_next = ST_IDLE;
      end
      default:   state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Output register.
  logic [M_TDATA_W-1:0] out_word;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if ((state == ST_FINISH) && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == ST_FINISH) && out_free) begin
      out_word                            <= '0;
      out_word[VAL_LSB    +: CELL_VALUE_W] <= div_q;
      out_word[INK_LSB]                    <= ink_seen;
      out_word[LEFT_LSB   +: COORD_W]      <= ink_left;
      out_word[TOP_LSB    +: COORD_W]      <= ink_top;
      out_word[RIGHT_LSB  +: COORD_W]      <= ink_right;
      out_word[BOTTOM_LSB +: COORD_W]      <= ink_bottom;
      out_word[SX_LSB     +: SHIFT_W]      <= sat_shift(sx);
      out_word[SY_LSB     +: SHIFT_W]      <= sat_shift(sy);
    end
  end

  assign m_tdata = out_word;

  // Once ink has been seen, the box is never inverted.
  a_box_ordered: assert property (@(posedge clk) disable iff (rst)
    ink_seen |-> ((ink_left <= ink_right) && (ink_top <= ink_bottom)))
    else $error("ink box inverted");

  // The cell sum cannot exceed full ink on every pixel of the cell.
  a_sum_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIVS) |-> (sum <= SUM_W'(INK_MAX) * SUM_W'(npix)))
    else $error("cell sum out of range");

  // The frame memory is only written while no cell scan is under way.
  a_write_idle: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> ((state == ST_IDLE) && !rd_valid))
    else $error("frame write during cell read");

  // A result appears only when the sequencer has finished a cell.
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> ($past(state) == ST_FINISH))
    else $error("result without finished cell");

endmodule

// ===== tb/digit_canvas_center_downsample_tb.sv =====
// Self-checking testbench for digit_canvas_center_downsample: it draws pixels, clears the
// ink box and requests grid cells, and checks each cell word against its own predictor.
// Depends on dccd_pkg and on the RTL of the block; it needs no other file.
module digit_canvas_center_downsample_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import dccd_pkg::*;

  localparam int MAX_SIDE    = 448;
  localparam int GRID_SIZE   = 28;
  localparam int STORE_DEPTH = MAX_SIDE * MAX_SIDE;
  localparam int FIELDS_W    = COL_LSB + CELL_IDX_W;

  // Action code the block has no use for, and register indexes it does not decode.
  localparam logic [ACTION_W-1:0]  ACT_UNUSED   = 2'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 2'd3;

  // Every field of an input word at all ones, padding left at zero.
  localparam logic [S_TDATA_W-1:0] FIELD_ONES =
    {{(S_TDATA_W - FIELDS_W){1'b0}}, {FIELDS_W{1'b1}}};

  // Canvas settings visited one phase after another; the middle ones are out of range
  // or not a multiple of the grid, so the block has to clamp and round them.
  localparam int PHASES = 7;
  localparam int PHASE_W [PHASES] = '{28, 448, 28, 0, 300, 100, 280};
  localparam int PHASE_H [PHASES] = '{28, 448, 448, 511, 55, 200, 280};

  typedef struct {
    logic [CELL_VALUE_W-1:0] cell_value;
    logic                    ink_found;
    logic [COORD_W-1:0]      box_left;
    logic [COORD_W-1:0]      box_top;
    logic [COORD_W-1:0]      box_right;
    logic [COORD_W-1:0]      box_bottom;
    logic [SHIFT_W-1:0]      shift_x;
    logic [SHIFT_W-1:0]      shift_y;
  } cell_result_t;

  // Mirror of the canvas: the pixel store, which entries have been written, the ink box,
  // the two canvas registers and the cell words still owed by the block.
  class cell_average_board;
    logic [CFG_W-1:0]   width_reg;
    logic [CFG_W-1:0]   height_reg;
    logic [COORD_W-1:0] ink_left;
    logic [COORD_W-1:0] ink_top;
    logic [COORD_W-1:0] ink_right;
    logic [COORD_W-1:0] ink_bottom;
    bit                 ink_seen;
    bit [RED_W-1:0]     pixels [STORE_DEPTH];
    bit                 written [STORE_DEPTH];
    cell_result_t       pending_cells [$];
    int                 failures;

    function new();
      width_reg  = RST_SIDE;
      height_reg = RST_SIDE;
      failures   = 0;
      clear_box();
    endfunction

    function void clear_box();
      ink_left   = '1;
      ink_top    = '1;
      ink_right  = '0;
      ink_bottom = '0;
      ink_seen   = 1'b0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
      if (idx == REG_CANVAS_WIDTH) width_reg = value;
      else if (idx == REG_CANVAS_HEIGHT) height_reg = value;
    endfunction

    // Side length in use: clamped to the legal span, then rounded down to the grid.
    function int side_of(logic [CFG_W-1:0] value);
      int v;
      v = value;
      if (v < GRID_SIZE) v = GRID_SIZE;
      if (v > MAX_SIDE) v = MAX_SIDE;
      return v - v % GRID_SIZE;
    endfunction

    function int recenter(logic [COORD_W-1:0] lo, logic [COORD_W-1:0] hi, int side);
      int l;
      int h;
      l = lo;
      h = hi;
      return l + (h - l) / 2 - side / 2;
    endfunction

    function logic [SHIFT_W-1:0] clip_shift(int s);
      if (s < SHIFT_MIN) s = SHIFT_MIN;
      if (s > SHIFT_MAX) s = SHIFT_MAX;
      return s[SHIFT_W-1:0];
    endfunction

    // Stored rows r0..r1 and columns c0..c1 that one cell samples after the
    // centering shift; the window is empty when r0 > r1 or c0 > c1.
    function void cell_window(int row, int col, output int r0, output int r1,
                              output int c0, output int c1, output int sx, output int sy);
      int w;
      int h;
      int cw;
      int ch;
      w  = side_of(width_reg);
      h  = side_of(height_reg);
      cw = w / GRID_SIZE;
      ch = h / GRID_SIZE;
      sx = 0;
      sy = 0;
      if (ink_seen) begin
        sx = recenter(ink_left, ink_right, w);
        sy = recenter(ink_top, ink_bottom, h);
      end
      r0 = row * ch + sy;
      r1 = r0 + ch - 1;
      c0 = col * cw + sx;
      c1 = c0 + cw - 1;
      if (r0 < 0) r0 = 0;
      if (r1 > h - 1) r1 = h - 1;
      if (c0 < 0) c0 = 0;
      if (c1 > w - 1) c1 = w - 1;
    endfunction

    // Called for every accepted input word, in acceptance order.
    function void note_word(logic [ACTION_W-1:0] act, logic [S_TDATA_W-1:0] data);
      int              x;
      int              y;
      int              w;
      int              h;
      int              r0;
      int              r1;
      int              c0;
      int              c1;
      int              sx;
      int              sy;
      int unsigned     sum;
      logic [RED_W-1:0] red;
      cell_result_t    res;
      x   = data[X_LSB +: COORD_W];
      y   = data[Y_LSB +: COORD_W];
      red = data[RED_LSB +: RED_W];
      w   = side_of(width_reg);
      h   = side_of(height_reg);
      case (act)
        ACT_CLEAR: clear_box();
        ACT_PIXEL: begin
          if (x < MAX_SIDE && y < MAX_SIDE) begin
            pixels[y * MAX_SIDE + x]  = red;
            written[y * MAX_SIDE + x] = 1'b1;
            // Ink off the canvas in use is stored but leaves the box alone.
            if (red == 0 && x < w && y < h) begin
              if (!ink_seen || x < ink_left) ink_left = x;
              if (!ink_seen || y < ink_top) ink_top = y;
              if (!ink_seen || x > ink_right) ink_right = x;
              if (!ink_seen || y > ink_bottom) ink_bottom = y;
              ink_seen = 1'b1;
            end
          end
        end
        ACT_CELL: begin
          cell_window(data[ROW_LSB +: CELL_IDX_W], data[COL_LSB +: CELL_IDX_W],
                      r0, r1, c0, c1, sx, sy);
          sum = 0;
          for (int r = r0; r <= r1; r++)
            for (int c = c0; c <= c1; c++)
              sum += INK_MAX - pixels[r * MAX_SIDE + c];
          res.cell_value = sum / ((w / GRID_SIZE) * (h / GRID_SIZE));
          res.ink_found  = ink_seen;
          res.box_left   = ink_left;
          res.box_top    = ink_top;
          res.box_right  = ink_right;
          res.box_bottom = ink_bottom;
          res.shift_x    = clip_shift(sx);
          res.shift_y    = clip_shift(sy);
          pending_cells.push_back(res);
        end
        default: ;
      endcase
    endfunction

    function void compare_field(string name, logic [8:0] expv, logic [8:0] actv, bit as_signed);
      if (actv !== expv) begin
        failures++;
        if (as_signed)
          $error("%s mismatch: expected %0d, actual %0d", name, $signed(expv), $signed(actv));
        else
          $error("%s mismatch: expected %0d, actual %0d", name, expv, actv);
      end
    endfunction

    function void check_cell(logic [M_TDATA_W-1:0] data);
      cell_result_t exp;
      if (pending_cells.size() == 0) begin
        failures++;
        $error("cell word %h arrived with no cell request waiting", data);
        return;
      end
      exp = pending_cells.pop_front();
      compare_field("cell_value", exp.cell_value, data[VAL_LSB +: CELL_VALUE_W], 1'b0);
      compare_field("ink_found", exp.ink_found, data[INK_LSB], 1'b0);
      compare_field("box_left", exp.box_left, data[LEFT_LSB +: COORD_W], 1'b0);
      compare_field("box_top", exp.box_top, data[TOP_LSB +: COORD_W], 1'b0);
      compare_field("box_right", exp.box_right, data[RIGHT_LSB +: COORD_W], 1'b0);
      compare_field("box_bottom", exp.box_bottom, data[BOTTOM_LSB +: COORD_W], 1'b0);
      compare_field("shift_x", exp.shift_x, data[SX_LSB +: SHIFT_W], 1'b1);
      compare_field("shift_y", exp.shift_y, data[SY_LSB +: SHIFT_W], 1'b1);
    endfunction
  endclass

  logic                    clk       = 1'b0;
  logic                    rst       = 1'b1;
  logic                    s_tvalid  = 1'b0;
  logic                    s_tready;
  // Fields from bit 0 up: pixel_x, pixel_y, red_level, cell_row, cell_col.
  logic [S_TDATA_W-1:0]    s_tdata   = '0;
  // Fields from bit 0 up: action.
  logic [ACTION_W-1:0]     s_tuser   = '0;
  logic                    m_tvalid;
  logic                    m_tready  = 1'b0;
  // Fields from bit 0 up: cell_value, ink_found, box_left, box_top, box_right,
  // box_bottom, shift_x, shift_y.
  logic [M_TDATA_W-1:0]    m_tdata;
  logic                    cfg_wen   = 1'b0;
  logic [CFG_IDX_W-1:0]    cfg_idx   = '0;
  logic [CFG_W-1:0]        cfg_wdata = '0;

  // When set, neither side idles; used for the closing stretch of the run.
  bit                      calm = 1'b0;
  int                      stall_count = 0;
  cell_average_board       board;

  digit_canvas_center_downsample #(
    .MAX_SIDE (MAX_SIDE),
    .GRID_SIZE(GRID_SIZE)
  ) uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_wen  (cfg_wen),
    .cfg_idx  (cfg_idx),
    .cfg_wdata(cfg_wdata)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // The receiver drops tready in random bursts. Sampling m_tvalid and m_tready
  // at the edge sees the values from before the edge, which is exactly the handshake.
  always @(posedge clk) begin
    if (stall_count == 0 && !calm && $urandom_range(0, 7) == 0)
      stall_count = $urandom_range(1, 10);
    if (stall_count > 0) begin
      m_tready <= 1'b0;
      stall_count--;
    end else begin
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid === 1'b1 && m_tready) board.check_cell(m_tdata);
  end

  // Random content in every field, padding bits at zero. Fields an action does not use
  // still carry random values so the block is seen to ignore them.
  function automatic logic [S_TDATA_W-1:0] random_data();
    logic [S_TDATA_W-1:0] d;
    d = S_TDATA_W'({$urandom, $urandom});
    d[S_TDATA_W-1:FIELDS_W] = '0;
    return d;
  endfunction

  function automatic logic [S_TDATA_W-1:0] pixel_data(int x, int y, int red);
    logic [S_TDATA_W-1:0] d;
    d = random_data();
    d[X_LSB +: COORD_W] = x;
    d[Y_LSB +: COORD_W] = y;
    d[RED_LSB +: RED_W] = red;
    return d;
  endfunction

  function automatic logic [S_TDATA_W-1:0] cell_data(int row, int col);
    logic [S_TDATA_W-1:0] d;
    d = random_data();
    d[ROW_LSB +: CELL_IDX_W] = row;
    d[COL_LSB +: CELL_IDX_W] = col;
    return d;
  endfunction

  // Presents one word and returns at the edge that accepts it. tvalid stays high on
  // return, so a caller that stops sending must lower it, which drain does.
  task automatic send_word(logic [ACTION_W-1:0] act, logic [S_TDATA_W-1:0] data);
    int gap;
    if (!calm && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 10);
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= act;
    s_tdata  <= data;
    do @(posedge clk); while (s_tready !== 1'b1);
    board.note_word(act, data);
  endtask

  // Stops sending, waits for every cell word owed, then lets settle more cycles pass
  // (at least one) so that words without a result have also left the block.
  task automatic drain(int settle);
    s_tvalid <= 1'b0;
    while (board.pending_cells.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  // A cell read must never touch a store entry that was never written. Any such entry
  // in the window is filled first with a pixel that is not ink, so the box and the
  // shift, and with them the window, stay as they are.
  task automatic read_cell(int row, int col);
    int r0;
    int r1;
    int c0;
    int c1;
    int sx;
    int sy;
    board.cell_window(row, col, r0, r1, c0, c1, sx, sy);
    for (int r = r0; r <= r1; r++)
      for (int c = c0; c <= c1; c++)
        if (!board.written[r * MAX_SIDE + c])
          send_word(ACT_PIXEL, pixel_data(c, r, $urandom_range(1, INK_MAX)));
    send_word(ACT_CELL, cell_data(row, col));
  endtask

  // Writes both canvas registers, then one index the block does not decode, back to
  // back. Only called while the block is idle.
  task automatic set_canvas(int width, int height);
    logic [CFG_IDX_W-1:0] idx;
    logic [CFG_W-1:0]     value;
    cfg_wen <= 1'b1;
    for (int i = 0; i < 3; i++) begin
      if (i == 0) begin
        idx   = REG_CANVAS_WIDTH;
        value = width;
      end else if (i == 1) begin
        idx   = REG_CANVAS_HEIGHT;
        value = height;
      end else begin
        idx   = $urandom_range(REG_SPARE_LO, REG_SPARE_HI);
        value = $urandom;
      end
      cfg_idx   <= idx;
      cfg_wdata <= value;
      @(posedge clk);
      board.write_reg(idx, value);
    end
    cfg_wen <= 1'b0;
  endtask

  // One phase is a series of digits: usually a clear, then a handful of ink pixels
  // scattered over a random box on the canvas with some noise mixed in, then a few cell
  // reads. Now and then the sender holds off until every cell word is back.
  task automatic run_phase(int words);
    int sent;
    int w;
    int h;
    int bx;
    int by;
    int bw;
    int bh;
    int pick;
    sent = 0;
    w = board.side_of(board.width_reg);
    h = board.side_of(board.height_reg);
    while (sent < words) begin
      if ($urandom_range(0, 4) != 0) begin
        send_word(ACT_CLEAR, random_data());
        sent++;
      end
      bw = $urandom_range(1, w);
      bh = $urandom_range(1, h);
      bx = $urandom_range(0, w - bw);
      by = $urandom_range(0, h - bh);
      repeat ($urandom_range(0, 30)) begin
        pick = $urandom_range(0, 19);
        if (pick == 0) begin
          send_word(ACT_UNUSED, random_data());
        end else if (pick == 1) begin
          // Anywhere in the coordinate range: off the canvas, or past the store.
          send_word(ACT_PIXEL, pixel_data($urandom_range(0, 511), $urandom_range(0, 511),
                                          $urandom_range(0, 1) ? 0 : $urandom_range(0, INK_MAX)));
        end else if (pick == 2) begin
          send_word(ACT_PIXEL, pixel_data($urandom_range(bx, bx + bw - 1),
                                          $urandom_range(by, by + bh - 1),
                                          $urandom_range(1, INK_MAX)));
          sent++;
        end else begin
          send_word(ACT_PIXEL, pixel_data($urandom_range(bx, bx + bw - 1),
                                          $urandom_range(by, by + bh - 1), 0));
          sent++;
        end
      end
      repeat ($urandom_range(2, 8)) begin
        if ($urandom_range(0, 9) == 0)
          read_cell($urandom_range(0, 31), $urandom_range(0, 31));
        else
          read_cell($urandom_range(0, GRID_SIZE - 1), $urandom_range(0, GRID_SIZE - 1));
        sent++;
      end
      if ($urandom_range(0, 3) == 0) drain(1);
    end
  endtask

  initial begin
    board = new();
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed part on the reset canvas of 280 x 280. A read with no ink must use a zero
    // shift; then ink at both corners of the canvas spans the whole box.
    read_cell(0, 0);
    send_word(ACT_PIXEL, pixel_data(0, 0, 0));
    // Ink off the canvas is stored but must not widen the box.
    send_word(ACT_PIXEL, pixel_data(MAX_SIDE - 1, MAX_SIDE - 1, 0));
    // Writes past the store are dropped entirely.
    send_word(ACT_PIXEL, pixel_data(MAX_SIDE, 5, 0));
    send_word(ACT_PIXEL, pixel_data(5, MAX_SIDE, 0));
    send_word(ACT_PIXEL, pixel_data(511, 511, INK_MAX));
    send_word(ACT_PIXEL, pixel_data(RST_SIDE - 1, RST_SIDE - 1, 0));
    send_word(ACT_PIXEL, pixel_data(100, 100, INK_MAX));
    send_word(ACT_UNUSED, FIELD_ONES);
    read_cell(0, 0);
    read_cell(GRID_SIZE - 1, GRID_SIZE - 1);
    // Cells beyond the grid fall wholly off the canvas.
    read_cell(31, 31);
    read_cell(31, 0);
    read_cell(0, 31);
    read_cell(14, 14);
    // A clear resets the box only; the store keeps its pixels.
    send_word(ACT_CLEAR, FIELD_ONES);
    read_cell(13, 13);
    send_word(ACT_PIXEL, pixel_data(RST_SIDE - 1, 0, 0));
    read_cell(0, GRID_SIZE - 1);
    read_cell(GRID_SIZE - 1, 0);

    // Random part, one phase per canvas setting. The last phase runs without idling.
    for (int p = 0; p < PHASES; p++) begin
      drain(20);
      set_canvas(PHASE_W[p], PHASE_H[p]);
      if (p == PHASES - 1) calm = 1'b1;
      run_phase(170);
    end

    drain(300);
    if (board.failures == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

  initial begin
    #20ms;
    $display("Test completed with failures");
    $finish;
  end

endmodule

// ===== digit_canvas_center_downsample.f =====
rtl/core/dccd_pkg.sv
rtl/core/dccd_div.sv
rtl/core/digit_canvas_center_downsample.sv
tb/digit_canvas_center_downsample_tb.sv
